// File: design/sco_pkg.sv
package sco_pkg;

	// default field widths
	localparam int COORD_BITS_DEF  = 24;
	localparam int RADIUS_BITS_DEF = 20;

	// load enables for the three register ranks of the wide multiplier
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
	} wm_ctl_t;

	// per-item side flags that ride along with the wide products
	typedef struct packed {
		logic guard_ok;   // neither invulnerable nor dead
		logic interior;   // nearest point lies strictly inside the segment
		logic near_lt;    // end-point case: squared distance below squared radius sum
	} flags_t;

endpackage

// File: design/sco_wide_mul.sv
module sco_wide_mul #(
	parameter int W = 50
) (
	input  logic             clk,
	input  sco_pkg::wm_ctl_t ctl,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	output logic [2*W-1:0]   p
);

	// split each operand in a low half of LO bits and a high half of HI bits
	localparam int LO = (W + 1) / 2;
	localparam int HI = W - LO;

	logic [2*LO-1:0]    ll_s1;
	logic [LO+HI-1:0]   lh_s1;
	logic [LO+HI-1:0]   hl_s1;
	logic [2*HI-1:0]    hh_s1;

	logic [2*LO-1:0]    ll_s2;
	logic [LO+HI:0]     mid_s2;
	logic [2*HI-1:0]    hh_s2;

	logic [2*W-1:0]     p_s3;

	// rank 1: four partial products
	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			ll_s1 <= (2*LO)'(a[LO-1:0]) * (2*LO)'(b[LO-1:0]);
			lh_s1 <= (LO+HI)'(a[LO-1:0]) * (LO+HI)'(b[W-1:LO]);
			hl_s1 <= (LO+HI)'(a[W-1:LO]) * (LO+HI)'(b[LO-1:0]);
			hh_s1 <= (2*HI)'(a[W-1:LO]) * (2*HI)'(b[W-1:LO]);
		end
	end

	// rank 2: merge the cross terms
	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			ll_s2  <= ll_s1;
			hh_s2  <= hh_s1;
			mid_s2 <= (LO+HI+1)'(lh_s1) + (LO+HI+1)'(hl_s1);
		end
	end

	// rank 3: hh and ll do not overlap, so one add finishes the product
	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			p_s3 <= {hh_s2, ll_s2} + ((2*W)'(mid_s2) << LO);
		end
	end

	assign p = p_s3;

endmodule

// File: design/sphere_capsule_overlap.sv
// Sphere against capsule overlap test, one object pair per item.
//
// Input channel (pair_valid / pair_stall): capsule segment start and end,
// capsule radius, sphere centre and radius, and the two guard flags.
// Coordinates are signed Q16.8, radii unsigned Q12.8; all math is exact
// integer math on squared distances.
// Output channel (hit_valid / hit_stall): one hit bit per item, in order.
//
// Throughput: one item per cycle, unless hit_stall holds the output long
// enough to fill every stage and raise pair_stall.
// The 9 register stages are: differences, 25x25 products,
// dot-product sums, end-point classification, three ranks of the split
// wide multipliers (L*|P|^2, R^2*L, t*t), the right-hand add, and the final
// compare into the output register.
// Every stage has its own valid bit. A stage takes new data when it is
// empty or when the stage behind it moves on, so a held result on the
// output only blocks the input once all nine stages are full.
// Reset (arst_n low) empties the pipeline; payload registers are not reset.
module sphere_capsule_overlap #(
	parameter int COORD_BITS  = sco_pkg::COORD_BITS_DEF,
	parameter int RADIUS_BITS = sco_pkg::RADIUS_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          pair_valid,
	output logic                          pair_stall,
	input  logic signed [COORD_BITS-1:0]  cap_start_x,
	input  logic signed [COORD_BITS-1:0]  cap_start_y,
	input  logic signed [COORD_BITS-1:0]  cap_start_z,
	input  logic signed [COORD_BITS-1:0]  cap_end_x,
	input  logic signed [COORD_BITS-1:0]  cap_end_y,
	input  logic signed [COORD_BITS-1:0]  cap_end_z,
	input  logic        [RADIUS_BITS-1:0] cap_radius,
	input  logic signed [COORD_BITS-1:0]  ball_x,
	input  logic signed [COORD_BITS-1:0]  ball_y,
	input  logic signed [COORD_BITS-1:0]  ball_z,
	input  logic        [RADIUS_BITS-1:0] ball_radius,
	input  logic        [1:0]             guard_flags,

	output logic                          hit_valid,
	input  logic                          hit_stall,
	output logic                          hit
);

	localparam int NS  = 9;                  // pipeline depth
	localparam int CB  = COORD_BITS;
	localparam int DW  = CB + 1;             // coordinate difference
	localparam int PRW = 2 * CB + 2;         // signed d*p product
	localparam int SQW = 2 * CB;             // one squared difference
	localparam int LW  = 2 * CB + 2;         // sum of three squares
	localparam int TW  = 2 * CB + 3;         // signed dot product t
	localparam int RSW = RADIUS_BITS + 1;    // radius sum
	localparam int R2W = 2 * RADIUS_BITS + 2;
	localparam int SW  = (LW > R2W) ? LW : R2W;
	localparam int PW  = 2 * SW;             // wide product
	localparam int RHW = PW + 1;             // R^2*L + t^2

	// ---------------------------------------------------------------
	// valid chain
	// ---------------------------------------------------------------
	logic [NS:1]   vld_q;
	logic [NS-1:0] vin;
	logic [NS:1]   rdy;

	assign vin = {vld_q[NS-1:1], pair_valid};

	always_comb begin
		rdy[NS] = !vld_q[NS] || !hit_stall;
		for (int k = NS - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vin[k-1];
				end
			end
		end
	end

	assign pair_stall = !rdy[1];
	assign hit_valid  = vld_q[NS];

	// ---------------------------------------------------------------
	// stage 1: differences D = E - S, P = B - S, Q = B - E
	// ---------------------------------------------------------------
	logic signed [CB-1:0] st [3];
	logic signed [CB-1:0] en [3];
	logic signed [CB-1:0] bl [3];

	assign st[0] = cap_start_x;
	assign st[1] = cap_start_y;
	assign st[2] = cap_start_z;
	assign en[0] = cap_end_x;
	assign en[1] = cap_end_y;
	assign en[2] = cap_end_z;
	assign bl[0] = ball_x;
	assign bl[1] = ball_y;
	assign bl[2] = ball_z;

	logic signed [DW-1:0] d_s1 [3];
	logic signed [DW-1:0] p_s1 [3];
	logic signed [DW-1:0] q_s1 [3];
	logic [RSW-1:0]       rsum_s1;
	logic                 guard_ok_s1;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= DW'(en[i]) - DW'(st[i]);
				p_s1[i] <= DW'(bl[i]) - DW'(st[i]);
				q_s1[i] <= DW'(bl[i]) - DW'(en[i]);
			end
			rsum_s1     <= RSW'(cap_radius) + RSW'(ball_radius);
			guard_ok_s1 <= (guard_flags == '0);
		end
	end

	// ---------------------------------------------------------------
	// stage 2: narrow products
	// ---------------------------------------------------------------
	logic signed [PRW-1:0] dp_s2 [3];
	logic [SQW-1:0]        dd_s2 [3];
	logic [SQW-1:0]        pp_s2 [3];
	logic [SQW-1:0]        qq_s2 [3];
	logic [R2W-1:0]        r2_s2;
	logic                  guard_ok_s2;

	// a square of a difference is below 2^(2*CB), so the low bits are exact
	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			for (int i = 0; i < 3; i++) begin
				dp_s2[i] <= PRW'(d_s1[i]) * PRW'(p_s1[i]);
				dd_s2[i] <= SQW'(SQW'(d_s1[i]) * SQW'(d_s1[i]));
				pp_s2[i] <= SQW'(SQW'(p_s1[i]) * SQW'(p_s1[i]));
				qq_s2[i] <= SQW'(SQW'(q_s1[i]) * SQW'(q_s1[i]));
			end
			r2_s2       <= R2W'(rsum_s1) * R2W'(rsum_s1);
			guard_ok_s2 <= guard_ok_s1;
		end
	end

	// ---------------------------------------------------------------
	// stage 3: t = P.D, L = |D|^2, |P|^2, |Q|^2
	// ---------------------------------------------------------------
	logic signed [TW-1:0] t_s3;
	logic [LW-1:0]        l_s3;
	logic [LW-1:0]        p2_s3;
	logic [LW-1:0]        q2_s3;
	logic [R2W-1:0]       r2_s3;
	logic                 guard_ok_s3;

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			t_s3        <= TW'(dp_s2[0]) + TW'(dp_s2[1]) + TW'(dp_s2[2]);
			l_s3        <= LW'(dd_s2[0]) + LW'(dd_s2[1]) + LW'(dd_s2[2]);
			p2_s3       <= LW'(pp_s2[0]) + LW'(pp_s2[1]) + LW'(pp_s2[2]);
			q2_s3       <= LW'(qq_s2[0]) + LW'(qq_s2[1]) + LW'(qq_s2[2]);
			r2_s3       <= r2_s2;
			guard_ok_s3 <= guard_ok_s2;
		end
	end

	// ---------------------------------------------------------------
	// stage 4: pick start, end or interior
	// ---------------------------------------------------------------
	// t <= 0 (also the zero-length segment) takes the start point,
	// t >= L takes the end point; in between 0 < t < L fits LW bits.
	logic            at_start;
	logic            at_end;
	logic            near_lt;

	assign at_start = t_s3[TW-1] || (t_s3 == '0);
	assign at_end   = !at_start && (t_s3 >= $signed({1'b0, l_s3}));
	assign near_lt  = at_start ? (SW'(p2_s3) < SW'(r2_s3)) : (SW'(q2_s3) < SW'(r2_s3));

	sco_pkg::flags_t flags_s4;
	logic [LW-1:0]   l_s4;
	logic [LW-1:0]   p2_s4;
	logic [LW-1:0]   tu_s4;
	logic [R2W-1:0]  r2_s4;

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			flags_s4.guard_ok <= guard_ok_s3;
			flags_s4.interior <= !at_start && !at_end;
			flags_s4.near_lt  <= near_lt;
			l_s4              <= l_s3;
			p2_s4             <= p2_s3;
			tu_s4             <= t_s3[LW-1:0];
			r2_s4             <= r2_s3;
		end
	end

	// ---------------------------------------------------------------
	// stages 5..7: interior test L*|P|^2 < R^2*L + t^2
	// ---------------------------------------------------------------
	sco_pkg::wm_ctl_t wm_ctl;
	logic [PW-1:0]    m_lp;
	logic [PW-1:0]    m_rl;
	logic [PW-1:0]    m_tt;

	assign wm_ctl.ld_s1 = rdy[5];
	assign wm_ctl.ld_s2 = rdy[6];
	assign wm_ctl.ld_s3 = rdy[7];

	sco_wide_mul #(.W(SW)) u_mul_lp (
		.clk (clk),
		.ctl (wm_ctl),
		.a   (SW'(l_s4)),
		.b   (SW'(p2_s4)),
		.p   (m_lp)
	);

	sco_wide_mul #(.W(SW)) u_mul_rl (
		.clk (clk),
		.ctl (wm_ctl),
		.a   (SW'(r2_s4)),
		.b   (SW'(l_s4)),
		.p   (m_rl)
	);

	sco_wide_mul #(.W(SW)) u_mul_tt (
		.clk (clk),
		.ctl (wm_ctl),
		.a   (SW'(tu_s4)),
		.b   (SW'(tu_s4)),
		.p   (m_tt)
	);

	sco_pkg::flags_t flags_s5;
	sco_pkg::flags_t flags_s6;
	sco_pkg::flags_t flags_s7;

	always_ff @(posedge clk) begin
		if (rdy[5]) flags_s5 <= flags_s4;
		if (rdy[6]) flags_s6 <= flags_s5;
		if (rdy[7]) flags_s7 <= flags_s6;
	end

	// ---------------------------------------------------------------
	// stage 8: right-hand side
	// ---------------------------------------------------------------
	sco_pkg::flags_t flags_s8;
	logic [PW-1:0]   lhs_s8;
	logic [RHW-1:0]  rhs_s8;

	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			flags_s8 <= flags_s7;
			lhs_s8   <= m_lp;
			rhs_s8   <= RHW'(m_rl) + RHW'(m_tt);
		end
	end

	// ---------------------------------------------------------------
	// stage 9: output register
	// ---------------------------------------------------------------
	logic hit_s9;

	always_ff @(posedge clk) begin
		if (rdy[9]) begin
			hit_s9 <= flags_s8.guard_ok &&
				(flags_s8.interior ? (RHW'(lhs_s8) < rhs_s8) : flags_s8.near_lt);
		end
	end

	assign hit = hit_s9;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	// an output slot that is free or draining never stalls the input
	a_no_stall_when_draining: assert property (@(posedge clk) disable iff (!arst_n)
		(!hit_valid || !hit_stall) |-> !pair_stall)
		else $error("input stalled while output can move");

	// input only stalls when every stage holds an item
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> (&vld_q))
		else $error("input stalled with a bubble in the pipeline");

	// a zero-length segment always resolves to the start point
	a_zero_len_start: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[3] && rdy[4] && (l_s3 == '0)) |=> !flags_s4.interior)
		else $error("zero-length segment classified as interior");

	// a guarded target never produces a hit
	a_guard_suppress: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NS-1] && rdy[NS] && !flags_s8.guard_ok) |=> !hit)
		else $error("hit raised for a guarded target");

	// the output register only loads while it is empty or being taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_valid && hit_stall) |=> (hit_valid && $stable(hit_s9)))
		else $error("held result lost or changed");

endmodule
